// File: design/fcc_ldu_pkg.sv
`default_nettype none

package fcc_ldu_pkg;

    localparam int DIR_COUNT = 12;
    localparam logic [3:0] NO_DIR = 4'd12;

    typedef enum logic [2:0] {
        OP_NEIGHBOR    = 3'd0,
        OP_REL_TO_ABS  = 3'd1,
        OP_ABS_TO_REL  = 3'd2,
        OP_UPDATE_REL  = 3'd3,
        OP_UPDATE_ABS  = 3'd4,
        OP_RESET_BASE  = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NOT_LATTICE = 2'd1,
        ST_BAD_DIR     = 2'd2
    } status_t;

    // trit: two-bit signed value in -1..1
    typedef logic [1:0] trit_t;
    typedef logic [2:0][1:0] vec3_t;
    typedef logic [2:0][2:0][1:0] mat3_t;

    typedef struct packed {
        logic [3:0] dir;
        status_t    status;
    } result_t;

    localparam trit_t TR_ZERO = 2'b00;
    localparam trit_t TR_POS  = 2'b01;
    localparam trit_t TR_NEG  = 2'b11;

    localparam mat3_t IDENTITY = 18'b01_00_00_00_01_00_00_00_01;

    function automatic logic [5:0] mk_row(input int a0, input int a1, input int a2);
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        w0 = a0;
        w1 = a1;
        w2 = a2;
        return {w2[1:0], w1[1:0], w0[1:0]};
    endfunction

    function automatic mat3_t mk_mat(input logic [5:0] r0, input logic [5:0] r1,
                                     input logic [5:0] r2);
        return {r2, r1, r0};
    endfunction

    // neighbor vectors, element 0 is x
    function automatic vec3_t dir_vec(input logic [3:0] d);
        vec3_t v;
        unique case (d)
            4'd0:    v = {TR_ZERO, TR_POS,  TR_POS };
            4'd1:    v = {TR_POS,  TR_POS,  TR_ZERO};
            4'd2:    v = {TR_POS,  TR_ZERO, TR_POS };
            4'd3:    v = {TR_ZERO, TR_POS,  TR_NEG };
            4'd4:    v = {TR_POS,  TR_NEG,  TR_ZERO};
            4'd5:    v = {TR_POS,  TR_ZERO, TR_NEG };
            4'd6:    v = {TR_ZERO, TR_NEG,  TR_POS };
            4'd7:    v = {TR_NEG,  TR_POS,  TR_ZERO};
            4'd8:    v = {TR_NEG,  TR_ZERO, TR_POS };
            4'd9:    v = {TR_ZERO, TR_NEG,  TR_NEG };
            4'd10:   v = {TR_NEG,  TR_NEG,  TR_ZERO};
            4'd11:   v = {TR_NEG,  TR_ZERO, TR_NEG };
            default: v = {TR_ZERO, TR_ZERO, TR_ZERO};
        endcase
        return v;
    endfunction

    function automatic mat3_t dir_rot(input logic [3:0] d);
        mat3_t m;
        unique case (d)
            4'd1:    m = mk_mat(mk_row(0, 0, -1), mk_row(0, 1, 0), mk_row(1, 0, 0));
            4'd2:    m = mk_mat(mk_row(1, 0, 0), mk_row(0, 0, -1), mk_row(0, 1, 0));
            4'd3:    m = mk_mat(mk_row(0, -1, 0), mk_row(1, 0, 0), mk_row(0, 0, 1));
            4'd4:    m = mk_mat(mk_row(0, 0, -1), mk_row(-1, 0, 0), mk_row(0, 1, 0));
            4'd5:    m = mk_mat(mk_row(0, -1, 0), mk_row(0, 0, -1), mk_row(1, 0, 0));
            4'd6:    m = mk_mat(mk_row(0, 1, 0), mk_row(-1, 0, 0), mk_row(0, 0, 1));
            4'd7:    m = mk_mat(mk_row(0, 0, 1), mk_row(0, 1, 0), mk_row(-1, 0, 0));
            4'd8:    m = mk_mat(mk_row(1, 0, 0), mk_row(0, 0, 1), mk_row(0, -1, 0));
            4'd9:    m = mk_mat(mk_row(-1, 0, 0), mk_row(0, -1, 0), mk_row(0, 0, 1));
            4'd10:   m = mk_mat(mk_row(0, 0, 1), mk_row(-1, 0, 0), mk_row(0, -1, 0));
            4'd11:   m = mk_mat(mk_row(0, -1, 0), mk_row(0, 0, 1), mk_row(-1, 0, 0));
            default: m = IDENTITY;
        endcase
        return m;
    endfunction

    function automatic logic signed [2:0] tmul(input trit_t a, input trit_t b);
        logic signed [2:0] sa;
        logic signed [2:0] sb;
        sa = $signed({a[1], a});
        sb = $signed({b[1], b});
        return sa * sb;
    endfunction

    function automatic logic signed [2:0] dot3(input trit_t a0, input trit_t a1,
                                               input trit_t a2, input trit_t b0,
                                               input trit_t b1, input trit_t b2);
        return tmul(a0, b0) + tmul(a1, b1) + tmul(a2, b2);
    endfunction

    function automatic logic fits3(input logic signed [2:0] s);
        return (s >= -3'sd1) && (s <= 3'sd1);
    endfunction

    function automatic logic [3:0] classify(input vec3_t v, input logic fits);
        logic [3:0] code;
        code = NO_DIR;
        for (int d = 0; d < DIR_COUNT; d++)
        begin
            if (fits && (v == dir_vec(4'(d))))
            begin
                code = 4'(d);
            end
        end
        return code;
    endfunction

endpackage

`default_nettype wire

// File: design/fcc_ldu_datapath.sv
`default_nettype none

module fcc_ldu_datapath #(
    parameter int COORD_BITS = 16
) (
    input  fcc_ldu_pkg::op_t                    op,
    input  logic [3:0]                          dir,
    input  logic [2:0][COORD_BITS-1:0]          first_pt,
    input  logic [2:0][COORD_BITS-1:0]          second_pt,
    input  fcc_ldu_pkg::mat3_t                  base,
    output fcc_ldu_pkg::result_t                res,
    output fcc_ldu_pkg::mat3_t                  base_next,
    output logic                                base_load
);

    import fcc_ldu_pkg::*;

    localparam logic signed [COORD_BITS:0] DIFF_MAX = {{COORD_BITS{1'b0}}, 1'b1};
    localparam logic signed [COORD_BITS:0] DIFF_MIN = {(COORD_BITS + 1){1'b1}};

    vec3_t             dv;
    mat3_t             rot;
    logic signed [COORD_BITS:0] diff [3];
    vec3_t             diff_v;
    logic              diff_fits;
    logic signed [2:0] rel_s [3];
    logic signed [2:0] abs_s [3];
    vec3_t             rel_v;
    vec3_t             abs_v;
    logic              rel_fits;
    logic              abs_fits;
    mat3_t             nb_rel;
    mat3_t             nb_abs;
    logic signed [2:0] nb_rel_s [3][3];
    logic signed [2:0] nb_abs_s [3][3];
    logic              bad_dir;
    logic [3:0]        code;

    assign dv      = dir_vec(dir);
    assign rot     = dir_rot(dir);
    assign bad_dir = (dir >= 4'(DIR_COUNT));

    // point difference, exact
    always_comb
    begin
        diff_fits = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            diff[i] = $signed({first_pt[i][COORD_BITS-1], first_pt[i]})
                    - $signed({second_pt[i][COORD_BITS-1], second_pt[i]});
            diff_v[i] = diff[i][1:0];
            diff_fits = diff_fits && (diff[i] >= DIFF_MIN) && (diff[i] <= DIFF_MAX);
        end
    end

    // direction mapping through the base
    always_comb
    begin
        rel_fits = 1'b1;
        abs_fits = 1'b1;
        for (int j = 0; j < 3; j++)
        begin
            rel_s[j] = dot3(dv[0], dv[1], dv[2], base[0][j], base[1][j], base[2][j]);
            abs_s[j] = dot3(base[j][0], base[j][1], base[j][2], dv[0], dv[1], dv[2]);
            rel_v[j] = rel_s[j][1:0];
            abs_v[j] = abs_s[j][1:0];
            rel_fits = rel_fits && fits3(rel_s[j]);
            abs_fits = abs_fits && fits3(abs_s[j]);
        end
    end

    // base products
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                nb_rel_s[i][j] = dot3(rot[i][0], rot[i][1], rot[i][2],
                                      base[0][j], base[1][j], base[2][j]);
                nb_abs_s[i][j] = dot3(base[i][0], base[i][1], base[i][2],
                                      rot[j][0], rot[j][1], rot[j][2]);
                nb_rel[i][j] = nb_rel_s[i][j][1:0];
                nb_abs[i][j] = nb_abs_s[i][j][1:0];
            end
        end
    end

    always_comb
    begin
        res.dir    = NO_DIR;
        res.status = ST_OK;
        base_next  = base;
        base_load  = 1'b0;
        code       = NO_DIR;
        unique case (op)
            OP_NEIGHBOR:
            begin
                code       = classify(diff_v, diff_fits);
                res.dir    = code;
                res.status = (code == NO_DIR) ? ST_NOT_LATTICE : ST_OK;
            end
            OP_REL_TO_ABS:
            begin
                if (bad_dir)
                begin
                    res.status = ST_BAD_DIR;
                end
                else
                begin
                    code       = classify(rel_v, rel_fits);
                    res.dir    = code;
                    res.status = (code == NO_DIR) ? ST_NOT_LATTICE : ST_OK;
                end
            end
            OP_ABS_TO_REL:
            begin
                if (bad_dir)
                begin
                    res.status = ST_BAD_DIR;
                end
                else
                begin
                    code       = classify(abs_v, abs_fits);
                    res.dir    = code;
                    res.status = (code == NO_DIR) ? ST_NOT_LATTICE : ST_OK;
                end
            end
            OP_UPDATE_REL:
            begin
                if (bad_dir)
                begin
                    res.status = ST_BAD_DIR;
                end
                else
                begin
                    base_next = nb_rel;
                    base_load = 1'b1;
                end
            end
            OP_UPDATE_ABS:
            begin
                if (bad_dir)
                begin
                    res.status = ST_BAD_DIR;
                end
                else
                begin
                    base_next = nb_abs;
                    base_load = 1'b1;
                end
            end
            OP_RESET_BASE:
            begin
                base_next = IDENTITY;
                base_load = 1'b1;
            end
            default:
            begin
                res.dir = NO_DIR;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: design/fcc_lattice_direction_unit.sv
// channel | handshake             | payload
// in      | in_valid / in_ready   | opcode, direction, first_x/y/z, second_x/y/z
// out     | out_valid / out_ready | result_direction, status
//
// one item per cycle sustained while the output is not stalled
// an input register feeds one pass of base-matrix logic into the result register
// on a base update or reset the base matrix updates as the item moves into the result register
// rst_n clears valid flags and sets the base matrix to identity
// a stalled output holds its result while the input register still takes one item

`default_nettype none

module fcc_lattice_direction_unit #(
    parameter int COORD_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [2:0]                   opcode,
    input  logic [3:0]                   direction,
    input  logic signed [COORD_BITS-1:0] first_x,
    input  logic signed [COORD_BITS-1:0] first_y,
    input  logic signed [COORD_BITS-1:0] first_z,
    input  logic signed [COORD_BITS-1:0] second_x,
    input  logic signed [COORD_BITS-1:0] second_y,
    input  logic signed [COORD_BITS-1:0] second_z,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [3:0]                   result_direction,
    output logic [1:0]                   status
);

    import fcc_ldu_pkg::*;

    logic                        s1_valid_reg;
    op_t                         op_reg;
    logic [3:0]                  dir_reg;
    logic [2:0][COORD_BITS-1:0]  first_reg;
    logic [2:0][COORD_BITS-1:0]  second_reg;
    logic                        out_valid_reg;
    result_t                     res_reg;
    mat3_t                       base_reg;
    result_t                     res_next;
    mat3_t                       base_next;
    logic                        base_load;
    logic                        advance;
    logic                        in_xfer;
    logic [2:0]                  nz_row [3];

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign in_xfer  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            base_reg      <= IDENTITY;
        end
        else
        begin
            if (in_xfer)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (advance && base_load)
            begin
                base_reg <= base_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg     <= op_t'(opcode);
            dir_reg    <= direction;
            first_reg  <= {first_z, first_y, first_x};
            second_reg <= {second_z, second_y, second_x};
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    fcc_ldu_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .op        (op_reg),
        .dir       (dir_reg),
        .first_pt  (first_reg),
        .second_pt (second_reg),
        .base      (base_reg),
        .res       (res_next),
        .base_next (base_next),
        .base_load (base_load)
    );

    assign out_valid        = out_valid_reg;
    assign result_direction = res_reg.dir;
    assign status           = res_reg.status;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            nz_row[i] = {|base_reg[i][2], |base_reg[i][1], |base_reg[i][0]};
        end
    end

    // base stays a signed permutation
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(nz_row[0]) && $onehot(nz_row[1]) && $onehot(nz_row[2]))
        else $error("base matrix is not a signed permutation");

    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result lost after transfer into result register");

    assert property (@(posedge clk) disable iff (!rst_n)
        advance && (op_reg == OP_RESET_BASE) |=> (base_reg == IDENTITY))
        else $error("base reset did not restore identity");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (res_reg.status != ST_OK) |-> (res_reg.dir == NO_DIR))
        else $error("error status with a direction code");

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(op_reg) && $stable(dir_reg))
        else $error("held item changed in input register");

endmodule

`default_nettype wire
